// ----- src/assert_macros.svh -----
// assertion macros used by the selector rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/wlcs_pkg.sv -----
// types, codes and helpers of the weighted least-connections selector
package wlcs_pkg;

	localparam logic [1:0] KIND_PICK = 2'd0;
	localparam logic [1:0] KIND_REL  = 2'd1;
	localparam logic [1:0] KIND_WR   = 2'd2;

	localparam logic [1:0] ST_SEL  = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	typedef struct packed {
		logic [15:0]        conn;
		logic [7:0]         weight;
		logic [7:0]         eff;
		logic signed [15:0] cur;
		logic [7:0]         fail;
		logic [7:0]         fmax;
		logic [15:0]        fwin;
		logic [31:0]        last;
		logic               down;
		logic               backup;
	} entry_t;

	function automatic entry_t rst_entry();
		entry_t e;
		e = '0;
		e.weight = 8'd1;
		e.eff = 8'd1;
		return e;
	endfunction

	function automatic logic [15:0] sat16(input logic signed [23:0] v);
		logic [15:0] r;
		if (v > 24'sd32767)
			r = 16'h7fff;
		else if (v < -24'sd32768)
			r = 16'h8000;
		else
			r = v[15:0];
		return r;
	endfunction

	function automatic logic usable(input entry_t e, input logic tried, input logic want_bk,
			input logic [31:0] now);
		logic blocked;
		logic [31:0] age;
		age = now - e.last;
		blocked = (e.fmax != 8'd0) && (e.fail >= e.fmax) && (age <= {16'd0, e.fwin});
		return !tried && !e.down && (e.backup == want_bk) && !blocked;
	endfunction

endpackage

// ----- src/wlcs_table.sv -----
// server table memory with one read and one write port and per-entry valid bits
module wlcs_table import wlcs_pkg::*; #(
	parameter int NUM_SERVERS = 16,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data
);
	entry_t mem [NUM_SERVERS];
	logic [NUM_SERVERS-1:0] vld_q;
	entry_t rd_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
		end
	end

	// never-written entries read as their reset contents
	assign rd_data = rd_vld_q ? rd_q : rst_entry();

endmodule

// ----- src/weighted_least_conn_selector.sv -----
// Weighted least-connections server selector. All per-server state sits in one table
// memory with a single registered read port and one write port. A pick walks the
// table one entry per cycle: a least-ratio walk over the primaries, a tie walk from
// the least entry upward when there are ties, a second least walk over the backups if
// no primary is eligible, and a clearing sweep when nothing is eligible; the chosen
// entry then takes a read-modify-write. A pick that continues a request already in the
// backup group walks only the backups. The next item is taken once the previous result
// is in the output register.
`include "assert_macros.svh"
module weighted_least_conn_selector import wlcs_pkg::*; #(
	parameter int NUM_SERVERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// new_request, now, server, failed, weight, fail_limit, timeout, is_down, is_backup
	input  logic [71:0] s_tdata,
	// kind
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// chosen, from_backup, zero fill
	output logic [7:0]  m_tdata,
	// status
	output logic [1:0]  m_tuser
);
	localparam int IDX_W = $clog2(NUM_SERVERS);
	localparam int CNT_W = $clog2(NUM_SERVERS + 1);
	localparam logic [CNT_W-1:0] CNT_N = CNT_W'(NUM_SERVERS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LEAST = 3'd1;
	localparam logic [2:0] S_TIE   = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;
	localparam logic [2:0] S_CLR   = 3'd4;
	localparam logic [2:0] S_UPD   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0] state_q;
	logic [1:0] kind_q;
	logic [31:0] now_q;
	logic failed_q, down_q, bkup_q;
	logic [7:0] weight_q, flim_q;
	logic [15:0] tout_q;

	logic [CNT_W-1:0] rd_cnt_q, lim_q;
	logic v_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [NUM_SERVERS-1:0] tried_q;
	logic bk_phase_q, want_bk_q, clr_all_q;
	logic found_q, many_q;
	logic [IDX_W-1:0] best_q;
	logic [15:0] best_conn_q;
	logic [7:0] best_w_q;
	logic signed [15:0] best_cur_q;
	logic [16:0] total_q;

	logic [1:0] res_status_q;
	logic [3:0] res_chosen_q;
	logic res_bk_q;
	logic [3:0] m_chosen_q;
	logic m_bk_q;
	logic [1:0] m_status_q;
	logic m_tvalid_q;

	logic rd_en, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	entry_t rd_data, wr_data, e;
	logic ok, tie_hit, walking, walk_done, accept, srv_ok;
	logic [23:0] lhs, rhs;
	logic signed [15:0] cur_add;
	logic [31:0] srv_ext, best_ext;

	wlcs_table #(.NUM_SERVERS(NUM_SERVERS), .IDX_W(IDX_W)) u_table (
		.clk(clk), .arst_n(arst_n),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
	);

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign srv_ext = {28'd0, s_tdata[36:33]};
	assign srv_ok = srv_ext < 32'(NUM_SERVERS);
	assign best_ext = 32'(best_q);

	assign walking = (state_q == S_LEAST) || (state_q == S_TIE) || (state_q == S_FIN) ||
		(state_q == S_CLR) || (state_q == S_UPD);
	assign rd_en = walking && (rd_cnt_q < lim_q);
	assign rd_addr = rd_cnt_q[IDX_W-1:0];
	assign walk_done = (rd_cnt_q == lim_q) && !v_s1;

	assign e = rd_data;
	assign ok = usable(e, tried_q[idx_s1], want_bk_q, now_q);
	assign lhs = 24'(e.conn) * 24'(best_w_q);
	assign rhs = 24'(best_conn_q) * 24'(e.weight);
	assign tie_hit = v_s1 && ok && (lhs == rhs);
	assign cur_add = sat16({{8{e.cur[15]}}, e.cur} + $signed({16'd0, e.eff}));
	assign wr_addr = idx_s1;

	always_comb begin
		wr_en = 1'b0;
		wr_data = e;
		case (state_q)
			S_TIE: begin
				if (tie_hit) begin
					wr_en = 1'b1;
					wr_data.cur = cur_add;
					if (e.eff < e.weight)
						wr_data.eff = e.eff + 8'd1;
				end
			end
			S_FIN: begin
				if (v_s1) begin
					wr_en = 1'b1;
					wr_data.cur = sat16({{8{e.cur[15]}}, e.cur} - $signed({7'd0, total_q}));
					wr_data.last = now_q;
					if (e.conn != 16'hffff)
						wr_data.conn = e.conn + 16'd1;
				end
			end
			S_CLR: begin
				if (v_s1 && (clr_all_q || e.backup)) begin
					wr_en = 1'b1;
					wr_data.fail = 8'd0;
				end
			end
			S_UPD: begin
				if (v_s1) begin
					wr_en = 1'b1;
					if (kind_q == KIND_REL) begin
						if (e.conn != 16'd0)
							wr_data.conn = e.conn - 16'd1;
						if (failed_q) begin
							if (e.fail != 8'hff)
								wr_data.fail = e.fail + 8'd1;
							wr_data.last = now_q;
						end
					end else begin
						wr_data.weight = weight_q;
						wr_data.eff = weight_q;
						wr_data.cur = '0;
						wr_data.fail = 8'd0;
						wr_data.fmax = flim_q;
						wr_data.fwin = tout_q;
						wr_data.down = down_q;
						wr_data.backup = bkup_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser;
			now_q <= s_tdata[32:1];
			failed_q <= s_tdata[37];
			weight_q <= s_tdata[45:38];
			flim_q <= s_tdata[53:46];
			tout_q <= s_tdata[69:54];
			down_q <= s_tdata[70];
			bkup_q <= s_tdata[71];
		end
		if (rd_en)
			idx_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rd_cnt_q <= '0;
			lim_q <= '0;
			v_s1 <= 1'b0;
			tried_q <= '0;
			bk_phase_q <= 1'b0;
			want_bk_q <= 1'b0;
			clr_all_q <= 1'b0;
			found_q <= 1'b0;
			many_q <= 1'b0;
			best_q <= '0;
			best_conn_q <= '0;
			best_w_q <= '0;
			best_cur_q <= '0;
			total_q <= '0;
			res_status_q <= ST_DONE;
			res_chosen_q <= '0;
			res_bk_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_status_q <= ST_DONE;
			m_chosen_q <= '0;
			m_bk_q <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			if (rd_en)
				rd_cnt_q <= rd_cnt_q + 1'b1;
			if (m_tvalid_q && m_tready && state_q != S_OUT)
				m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_status_q <= ST_DONE;
						res_chosen_q <= '0;
						res_bk_q <= 1'b0;
						case (s_tuser)
							KIND_PICK: begin
								if (s_tdata[0]) begin
									tried_q <= '0;
									bk_phase_q <= 1'b0;
									want_bk_q <= 1'b0;
								end else begin
									want_bk_q <= bk_phase_q;
								end
								clr_all_q <= 1'b0;
								found_q <= 1'b0;
								many_q <= 1'b0;
								rd_cnt_q <= '0;
								lim_q <= CNT_N;
								state_q <= S_LEAST;
							end
							KIND_REL, KIND_WR: begin
								if (srv_ok) begin
									rd_cnt_q <= CNT_W'(srv_ext[IDX_W-1:0]);
									lim_q <= CNT_W'(srv_ext[IDX_W-1:0]) + 1'b1;
									state_q <= S_UPD;
								end else begin
									state_q <= S_OUT;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_LEAST: begin
					if (v_s1 && ok) begin
						if (!found_q || lhs < rhs) begin
							found_q <= 1'b1;
							many_q <= 1'b0;
							best_q <= idx_s1;
							best_conn_q <= e.conn;
							best_w_q <= e.weight;
						end else if (lhs == rhs) begin
							many_q <= 1'b1;
						end
					end
					if (walk_done) begin
						total_q <= '0;
						if (!found_q) begin
							if (!want_bk_q) begin
								// primaries exhausted: move on to the backup group
								want_bk_q <= 1'b1;
								bk_phase_q <= 1'b1;
								clr_all_q <= 1'b1;
								tried_q <= '0;
								rd_cnt_q <= '0;
							end else begin
								rd_cnt_q <= '0;
								state_q <= S_CLR;
							end
						end else begin
							rd_cnt_q <= CNT_W'(best_q);
							lim_q <= many_q ? CNT_N : CNT_W'(best_q) + 1'b1;
							state_q <= many_q ? S_TIE : S_FIN;
						end
					end
				end
				S_TIE: begin
					if (tie_hit) begin
						total_q <= total_q + 17'(e.eff);
						if (idx_s1 == best_q) begin
							best_cur_q <= cur_add;
						end else if (cur_add > best_cur_q) begin
							best_q <= idx_s1;
							best_conn_q <= e.conn;
							best_w_q <= e.weight;
							best_cur_q <= cur_add;
						end
					end
					if (walk_done) begin
						rd_cnt_q <= CNT_W'(best_q);
						lim_q <= CNT_W'(best_q) + 1'b1;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (v_s1) begin
						tried_q[best_q] <= 1'b1;
						res_status_q <= ST_SEL;
						res_chosen_q <= best_ext[3:0];
						res_bk_q <= want_bk_q;
						state_q <= S_OUT;
					end
				end
				S_CLR: begin
					if (walk_done) begin
						res_status_q <= ST_BUSY;
						state_q <= S_OUT;
					end
				end
				S_UPD: begin
					if (v_s1)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= res_status_q;
						m_chosen_q <= res_chosen_q;
						m_bk_q <= res_bk_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser = m_status_q;
	assign m_tdata = {3'd0, m_bk_q, m_chosen_q};

	`ASSERT_IMPL(a_rw_apart, clk, arst_n, wr_en && rd_en, wr_addr != rd_addr)
	`ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, accept, state_q != S_IDLE)
	`ASSERT_IMPL(a_no_read_idle, clk, arst_n, state_q == S_IDLE || state_q == S_OUT, !v_s1)
	`ASSERT_NEXT(a_pick_marks_tried, clk, arst_n, state_q == S_FIN && v_s1,
		tried_q[$past(best_q)])

endmodule
